// File: rtl/ial_pkg.sv
// Shared constants for the indexed array list: sizes, operation and status codes.
`timescale 1ns / 1ps
`default_nettype none
package ial_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    localparam int OP_W = 2;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: rtl/ial_ram.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ial_ram #(
    parameter int DEPTH     = ial_pkg::DEPTH,
    parameter int WORD_BITS = ial_pkg::WORD_BITS,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/indexed_array_list_unit.sv
// Top level of the indexed array list: sequencer around the entry memory.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_operation, i_position, i_element
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_item_count, o_read_value
//
// Insert at p shifts entries p..count-1 up one place from the top down, then writes
// the element; delete at p shifts entries p+1..count-1 down one place. One entry is
// moved per cycle through the memory's single read and single write port.
// Reset clears the count and the handshake state; memory contents are not cleared.
// A new word is taken once the previous op has reached the output register, even
// while that result still waits on i_out_ready.
`timescale 1ns / 1ps
`default_nettype none
module indexed_array_list_unit #(
    parameter int DEPTH     = ial_pkg::DEPTH,
    parameter int WORD_BITS = ial_pkg::WORD_BITS,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [ial_pkg::OP_W-1:0]    i_operation,
    input  wire logic [CW-1:0]               i_position,
    input  wire logic signed [WORD_BITS-1:0] i_element,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [ial_pkg::ST_W-1:0]    o_status,
    output logic      [CW-1:0]               o_item_count,
    output logic signed [WORD_BITS-1:0]      o_read_value
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_LAST = 3'd2;
    localparam logic [2:0] S_DEL      = 3'd3;
    localparam logic [2:0] S_RD       = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [AW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_pos, n_pos;
    logic [WORD_BITS-1:0]        r_elem, n_elem;
    logic [ial_pkg::ST_W-1:0]    r_res_status, n_res_status;
    logic [WORD_BITS-1:0]        r_res_value, n_res_value;
    logic                        r_out_valid, n_out_valid;
    logic [ial_pkg::ST_W-1:0]    r_out_status, n_out_status;
    logic [CW-1:0]               r_out_count, n_out_count;
    logic [WORD_BITS-1:0]        r_out_value, n_out_value;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    ial_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_item_count = r_out_count;
    assign o_read_value = r_out_value;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_elem       = r_elem;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_value  = r_out_value;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = r_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos        = i_position;
                    n_elem       = i_element;
                    n_res_status = ial_pkg::ST_DONE;
                    n_res_value  = '0;
                    n_state      = S_DONE;
                    case (i_operation)
                        ial_pkg::OP_INSERT: begin
                            if (i_position > r_count) begin
                                n_res_status = ial_pkg::ST_RANGE;
                            end else if (r_count == DEPTH_C) begin
                                n_res_status = ial_pkg::ST_FULL;
                            end else if (i_position == r_count) begin
                                // append at the tail, nothing to move
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_position);
                                mem_wdata = i_element;
                                n_count   = r_count + 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(r_count - 1'b1);
                                n_idx     = AW'(r_count);
                                n_state   = S_INS;
                            end
                        end
                        ial_pkg::OP_DELETE: begin
                            if (i_position >= r_count) begin
                                n_res_status = ial_pkg::ST_RANGE;
                            end else if (i_position == r_count - 1'b1) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(i_position + 1'b1);
                                n_idx     = AW'(i_position);
                                n_state   = S_DEL;
                            end
                        end
                        ial_pkg::OP_READ: begin
                            if (i_position >= r_count) begin
                                n_res_status = ial_pkg::ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(i_position);
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // write entry idx from idx-1 read last cycle, fetch the next lower one
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                if (AW'(r_idx - 1'b1) == AW'(r_pos)) begin
                    n_state = S_INS_LAST;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx - AW'(2));
                    n_idx     = AW'(r_idx - 1'b1);
                end
            end
            S_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_pos);
                mem_wdata = r_elem;
                n_count   = r_count + 1'b1;
                n_state   = S_DONE;
            end
            S_DEL: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                if (CW'(r_idx) + CW'(2) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx + AW'(2));
                    n_idx     = AW'(r_idx + 1'b1);
                end
            end
            S_RD: begin
                n_res_value = mem_rdata;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_count  = r_count;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_elem       <= n_elem;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_value  <= n_out_value;
    end

endmodule
`default_nettype wire

// File: rtl/ial_checker.sv
// Port-level checks for the indexed array list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ial_checker #(
    parameter int DEPTH     = ial_pkg::DEPTH,
    parameter int WORD_BITS = ial_pkg::WORD_BITS,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [ial_pkg::ST_W-1:0] o_status,
    input wire logic [CW-1:0]            o_item_count,
    input wire logic [WORD_BITS-1:0]     o_read_value
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_item_count)
            && $stable(o_read_value))
        else $error("stalled result word changed");

    // only a successful op may carry a value
    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ial_pkg::ST_DONE |-> o_read_value == '0)
        else $error("failed op returned a value");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ial_pkg::ST_FULL |-> o_item_count == CW'(DEPTH))
        else $error("full status with list not full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_item_count <= CW'(DEPTH))
        else $error("count above depth");

endmodule

bind indexed_array_list_unit ial_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
) u_ial_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_item_count (o_item_count),
    .o_read_value (o_read_value)
);
`default_nettype wire
